// ===== sv/dot_star_pattern_matcher_assert.svh =====
// Assertion macros shared by the dot-star pattern matcher modules.
`ifndef DOT_STAR_PATTERN_MATCHER_ASSERT_SVH
`define DOT_STAR_PATTERN_MATCHER_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define DSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define DSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/dsm_pkg.sv =====
// Shared types and constants for the dot-star pattern matcher.
`timescale 1ns / 1ps

package dsm_pkg;

  localparam int MAX_ELEMENTS_DEFAULT = 16;
  localparam int SYMBOL_W = 8;

  localparam logic [SYMBOL_W-1:0] DOT_BYTE = 8'h2E;
  localparam logic [SYMBOL_W-1:0] STAR_BYTE = 8'h2A;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_TEXT   = 2'd2,
    KIND_END    = 2'd3
  } kind_e_t;

  typedef struct packed {
    logic                fire;
    kind_e_t             kind;
    logic [SYMBOL_W-1:0] symbol;
  } cmd_t;

endpackage

// ===== sv/dsm_pattern_store.sv =====
// Pattern element store: element bytes, repeat marks, element count and overflow flag.
`timescale 1ns / 1ps
`include "dot_star_pattern_matcher_assert.svh"

module dsm_pattern_store #(
  parameter int MAX_ELEMENTS = dsm_pkg::MAX_ELEMENTS_DEFAULT,
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  dsm_pkg::cmd_t                               cmd,
  output logic [MAX_ELEMENTS-1:0][dsm_pkg::SYMBOL_W-1:0] symbols,
  output logic [MAX_ELEMENTS-1:0]                     repeats,
  output logic [CNT_W-1:0]                            count,
  output logic                                        too_long
);

  logic last_repeats;
  logic append;
  logic mark_star;
  logic add_element;
  logic full;

  always_comb begin
    last_repeats = 1'b0;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      if (count == CNT_W'(k + 1)) begin
        last_repeats = repeats[k];
      end
    end
  end

  assign full = (count == CNT_W'(MAX_ELEMENTS));
  assign append = cmd.fire && (cmd.kind == dsm_pkg::KIND_APPEND) && !too_long;
  assign mark_star = append && (cmd.symbol == dsm_pkg::STAR_BYTE) &&
                     (count != '0) && !last_repeats;
  assign add_element = append && !mark_star && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      too_long <= 1'b0;
    end else if (cmd.fire && (cmd.kind == dsm_pkg::KIND_CLEAR)) begin
      count <= '0;
      too_long <= 1'b0;
    end else if (add_element) begin
      count <= count + CNT_W'(1);
    end else if (append && !mark_star) begin
      too_long <= 1'b1;
    end
  end

  // Element bytes and marks are only read below the count, so they need no reset.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      if (add_element && (count == CNT_W'(k))) begin
        symbols[k] <= cmd.symbol;
        repeats[k] <= 1'b0;
      end
      if (mark_star && (count == CNT_W'(k + 1))) begin
        repeats[k] <= 1'b1;
      end
    end
  end

  `DSM_ASSERT(a_count_in_range, count <= CNT_W'(MAX_ELEMENTS), "element count beyond capacity")
  `DSM_ASSERT(a_overflow_only_when_full, too_long |-> full, "overflow flag set below capacity")
  `DSM_ASSERT_ALWAYS(a_reset_empty, rst |=> (count == '0) && !too_long, "store not empty after reset")

endmodule

// ===== sv/dsm_position_nfa.sv =====
// Active-position set of the pattern automaton, advanced by one text byte per item.
`timescale 1ns / 1ps
`include "dot_star_pattern_matcher_assert.svh"

module dsm_position_nfa #(
  parameter int MAX_ELEMENTS = dsm_pkg::MAX_ELEMENTS_DEFAULT,
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  dsm_pkg::cmd_t                                  cmd,
  input  logic [MAX_ELEMENTS-1:0][dsm_pkg::SYMBOL_W-1:0] symbols,
  input  logic [MAX_ELEMENTS-1:0]                        repeats,
  input  logic [CNT_W-1:0]                               count,
  output logic                                           hit
);

  logic [MAX_ELEMENTS:0]   active;
  logic [MAX_ELEMENTS:0]   active_next;
  logic [MAX_ELEMENTS:0]   reach;
  logic [MAX_ELEMENTS:0]   step;
  logic [MAX_ELEMENTS-1:0] live;

  always_comb begin
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      live[k] = CNT_W'(k) < count;
    end
  end

  // Closure over repeating elements; this is a carry-style single-bit chain.
  always_comb begin
    reach = active;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      if (reach[k] && live[k] && repeats[k]) begin
        reach[k + 1] = 1'b1;
      end
    end
  end

  always_comb begin
    step = '0;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      if (reach[k] && live[k] &&
          ((symbols[k] == cmd.symbol) || (symbols[k] == dsm_pkg::DOT_BYTE))) begin
        if (repeats[k]) begin
          step[k] = 1'b1;
        end else begin
          step[k + 1] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k <= MAX_ELEMENTS; k++) begin
      if (count == CNT_W'(k)) begin
        hit = reach[k];
      end
    end
  end

  always_comb begin
    active_next = active;
    if (cmd.fire) begin
      case (cmd.kind)
        dsm_pkg::KIND_TEXT: active_next = step;
        default: active_next = (MAX_ELEMENTS + 1)'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= (MAX_ELEMENTS + 1)'(1);
    end else begin
      active <= active_next;
    end
  end

endmodule

// ===== sv/dot_star_pattern_matcher.sv =====
// Top level of the dot-star pattern matcher: input register, store, automaton, result register.
`timescale 1ns / 1ps
`include "dot_star_pattern_matcher_assert.svh"

// The matcher takes one item per clock cycle unless stalled as described below. Each
// accepted item is held in an input register, from which the pattern store and the
// active-position set are updated in a single pass; an end-of-text item loads the
// result register as it leaves the input register, so its result passes through both
// registers. The rate is set by the update of the active-position set, which covers
// all MAX_ELEMENTS pattern elements in parallel. A result that waits to be taken holds
// the next end-of-text item in the input register, and the input stalls behind that
// item until the result is taken; other items keep flowing.

module dot_star_pattern_matcher #(
  parameter int MAX_ELEMENTS = dsm_pkg::MAX_ELEMENTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [1:0]                    kind,
  input  logic [dsm_pkg::SYMBOL_W-1:0]  symbol,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic                          matched,
  output logic                          overflow
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic                                           s1_valid;
  dsm_pkg::kind_e_t                               s1_kind;
  logic [dsm_pkg::SYMBOL_W-1:0]                   s1_symbol;
  logic                                           advance;
  dsm_pkg::cmd_t                                  cmd;
  logic [MAX_ELEMENTS-1:0][dsm_pkg::SYMBOL_W-1:0] symbols;
  logic [MAX_ELEMENTS-1:0]                        repeats;
  logic [CNT_W-1:0]                               count;
  logic                                           too_long;
  logic                                           hit;

  assign advance = s1_valid &&
                   ((s1_kind != dsm_pkg::KIND_END) || !result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  assign cmd.fire = advance;
  assign cmd.kind = s1_kind;
  assign cmd.symbol = s1_symbol;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_kind <= dsm_pkg::kind_e_t'(kind);
      s1_symbol <= symbol;
    end
  end

  dsm_pattern_store #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .symbols(symbols),
    .repeats(repeats),
    .count(count),
    .too_long(too_long)
  );

  dsm_position_nfa #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_nfa (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .symbols(symbols),
    .repeats(repeats),
    .count(count),
    .hit(hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && (s1_kind == dsm_pkg::KIND_END)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (s1_kind == dsm_pkg::KIND_END)) begin
      matched <= hit && !too_long;
      overflow <= too_long;
    end
  end

  `DSM_ASSERT(a_result_from_end_item, $rose(result_valid) |-> $past(advance && (s1_kind == dsm_pkg::KIND_END)), "result without an end-of-text item")
  `DSM_ASSERT(a_overflow_never_matches, (result_valid && overflow) |-> !matched, "match reported with overflow")
  `DSM_ASSERT(a_no_needless_stall, (s1_valid && !result_valid) |-> advance, "item stalled with free result register")
  `DSM_ASSERT_ALWAYS(a_reset_no_result, rst |=> !result_valid && !s1_valid, "pipeline not empty after reset")

endmodule
